>>> rtl/core/lgh_pkg.sv
// ----------------------------------------------------------------------------
// lgh_pkg
// Shared widths, fixed-point constants and the request tag type of the
// logistic gradient/hessian pipeline.
// ----------------------------------------------------------------------------
package lgh_pkg;

  // Field widths
  localparam int LogitW = 15;
  localparam int LabelW = 16;
  localparam int ProbW  = 16;
  localparam int GradW  = 17;
  localparam int HessW  = 14;

  // Exponent and polynomial widths
  localparam int ExpW  = 31;   // logit * log2(e), Q25, signed
  localparam int ShW   = 6;    // integer part of the exponent, signed
  localparam int FracW = 16;   // fractional part, Q16
  localparam int P1W   = 15;
  localparam int P2W   = 16;
  localparam int PW    = 17;   // 2^f in Q16

  // Divider widths
  localparam int DenW     = 39;
  localparam int DivSteps = 16;
  localparam int QuoW     = DivSteps;

  // Logit clip in Q10
  localparam logic signed [LogitW-1:0] ClipQ10    = 15'sd15360;
  localparam logic signed [LogitW-1:0] NegClipQ10 = -15'sd15360;

  // log2(e) in Q15
  localparam logic signed [17:0] Log2eQ15 = 18'sd47274;

  // Cubic coefficients for 2^f, Q16
  localparam logic [PW-1:0]  CoefA = 17'd65536;
  localparam logic [P2W-1:0] CoefB = 16'd45426;
  localparam logic [P1W-1:0] CoefC = 15'd14904;
  localparam logic [12:0]    CoefD = 13'd5206;

  // One in the den term, Q16
  localparam logic [DenW-1:0] OneQ16 = 39'd65536;

  // One in the result scale, Q15
  localparam logic [ProbW-1:0] OneQ15 = 16'd32768;
  localparam logic signed [GradW:0] GradMin = -18'sd32768;
  localparam logic [31:0] HessRound = 32'd16384;

  // Tag that travels with each request
  typedef struct packed {
    logic              valid;
    logic [LabelW-1:0] label;
  } tag_t;

endpackage

>>> rtl/core/lgh_exp2.sv
// ----------------------------------------------------------------------------
// lgh_exp2
// Four-stage power-of-two front end: clip the logit, scale by log2(e), split
// the exponent and evaluate the cubic for 2^f by Horner over three stages.
// ----------------------------------------------------------------------------
module lgh_exp2 (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  lgh_pkg::tag_t                         tag_i,
  input  logic signed [lgh_pkg::LogitW-1:0]     logit_i,
  output lgh_pkg::tag_t                         tag_o,
  output logic signed [lgh_pkg::ShW-1:0]        n_o,
  output logic [lgh_pkg::PW-1:0]                p_o
);

  logic signed [lgh_pkg::LogitW-1:0] x;
  logic signed [32:0]                e_full;
  logic signed [lgh_pkg::ExpW-1:0]   e_d, e_q;
  lgh_pkg::tag_t                     tag1_q, tag2_q, tag3_q, tag4_q;

  logic [lgh_pkg::FracW-1:0]         f_d, f2_q, f3_q;
  logic signed [lgh_pkg::ShW-1:0]    n_d, n2_q, n3_q, n4_q;
  logic [28:0]                       prod1;
  logic [30:0]                       prod2;
  logic [31:0]                       prod3;
  logic [lgh_pkg::P1W-1:0]           p1_d, p1_q;
  logic [lgh_pkg::P2W-1:0]           p2_d, p2_q;
  logic [lgh_pkg::PW-1:0]            p3_d, p3_q;

  // Stage 1: clip and scale by log2(e)
  always_comb begin
    if (logit_i > lgh_pkg::ClipQ10) begin
      x = lgh_pkg::ClipQ10;
    end else if (logit_i < lgh_pkg::NegClipQ10) begin
      x = lgh_pkg::NegClipQ10;
    end else begin
      x = logit_i;
    end
  end

  assign e_full = x * lgh_pkg::Log2eQ15;
  assign e_d    = e_full[lgh_pkg::ExpW-1:0];

  // Stage 2: split exponent (floor by two's-complement truncation), first Horner step
  assign n_d   = e_q[30:25];
  assign f_d   = e_q[24:9];
  assign prod1 = f_d * lgh_pkg::CoefD;
  assign p1_d  = lgh_pkg::CoefC + lgh_pkg::P1W'(prod1[28:16]);

  // Stage 3: second Horner step
  assign prod2 = f2_q * p1_q;
  assign p2_d  = lgh_pkg::CoefB + lgh_pkg::P2W'(prod2[30:16]);

  // Stage 4: last Horner step
  assign prod3 = f3_q * p2_q;
  assign p3_d  = lgh_pkg::CoefA + lgh_pkg::PW'(prod3[31:16]);

  // Advance all stages together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
      tag4_q <= '0;
    end else if (en_i) begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
      tag4_q <= tag3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q  <= e_d;
      f2_q <= f_d;
      n2_q <= n_d;
      p1_q <= p1_d;
      f3_q <= f2_q;
      n3_q <= n2_q;
      p2_q <= p2_d;
      n4_q <= n3_q;
      p3_q <= p3_d;
    end
  end

  assign tag_o = tag4_q;
  assign n_o   = n4_q;
  assign p_o   = p3_q;

endmodule

>>> rtl/core/lgh_div.sv
// ----------------------------------------------------------------------------
// lgh_div
// Sigmoid divider: forms num/den from 2^f and the shift, builds the rounded
// dividend, then resolves one quotient bit per stage in a restoring pipeline.
// ----------------------------------------------------------------------------
module lgh_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  lgh_pkg::tag_t                     tag_i,
  input  logic signed [lgh_pkg::ShW-1:0]    n_i,
  input  logic [lgh_pkg::PW-1:0]            p_i,
  output lgh_pkg::tag_t                     tag_o,
  output logic [lgh_pkg::QuoW-1:0]          quo_o
);

  localparam int DenW  = lgh_pkg::DenW;
  localparam int Steps = lgh_pkg::DivSteps;
  localparam int DivW  = DenW + Steps;

  logic [DenW-1:0]        p_ext;
  logic [lgh_pkg::ShW-1:0] nmag;
  logic [DenW-1:0]        num_d, den_d, num_q, den_a_q;
  lgh_pkg::tag_t          tag_a_q;
  logic [DivW-1:0]        dvd;

  logic [DenW-1:0]             rem_q [0:Steps];
  logic [DenW-1:0]             den_q [0:Steps];
  logic [Steps-1:0]            low_q [0:Steps];
  logic [lgh_pkg::QuoW-1:0]    quo_q [0:Steps];
  lgh_pkg::tag_t               tag_q [0:Steps];

  // Stage A: shift 2^f into numerator and denominator
  assign p_ext = DenW'(p_i);
  assign nmag  = lgh_pkg::ShW'(0) - n_i;

  always_comb begin
    if (!n_i[lgh_pkg::ShW-1]) begin
      num_d = p_ext << n_i[4:0];
      den_d = lgh_pkg::OneQ16 + num_d;
    end else begin
      num_d = p_ext;
      den_d = (lgh_pkg::OneQ16 << nmag[4:0]) + p_ext;
    end
  end

  // Stage B: dividend with half-divisor rounding term
  assign dvd = {1'b0, num_q, 15'b0} + DivW'(den_a_q[DenW-1:1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q  <= '0;
      tag_q[0] <= '0;
    end else if (en_i) begin
      tag_a_q  <= tag_i;
      tag_q[0] <= tag_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q    <= num_d;
      den_a_q  <= den_d;
      rem_q[0] <= dvd[DivW-1:Steps];
      low_q[0] <= dvd[Steps-1:0];
      den_q[0] <= den_a_q;
      quo_q[0] <= '0;
    end
  end

  // Restoring steps, one quotient bit each
  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [DenW:0]   trial;
    logic            ge;
    logic [DenW:0]   diff;
    logic [DenW-1:0] rem_d;

    assign trial = {rem_q[k], low_q[k][Steps-1]};
    assign ge    = trial >= {1'b0, den_q[k]};
    assign diff  = trial - {1'b0, den_q[k]};
    assign rem_d = ge ? diff[DenW-1:0] : trial[DenW-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k+1] <= '0;
      end else if (en_i) begin
        tag_q[k+1] <= tag_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= rem_d;
        low_q[k+1] <= {low_q[k][Steps-2:0], 1'b0};
        den_q[k+1] <= den_q[k];
        quo_q[k+1] <= {quo_q[k][lgh_pkg::QuoW-2:0], ge};
      end
    end
  end

  assign tag_o = tag_q[Steps];
  assign quo_o = quo_q[Steps];

endmodule

>>> rtl/core/lgh_out.sv
// ----------------------------------------------------------------------------
// lgh_out
// Result stage: clamp the probability, form the saturated gradient and the
// rounded hessian, and hold results in an output register plus skid entry.
// ----------------------------------------------------------------------------
module lgh_out (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lgh_pkg::tag_t                      tag_i,
  input  logic [lgh_pkg::QuoW-1:0]           quo_i,
  output logic                               en_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [lgh_pkg::ProbW-1:0]          probability_o,
  output logic signed [lgh_pkg::GradW-1:0]   gradient_o,
  output logic [lgh_pkg::HessW-1:0]          hessian_o
);

  logic [lgh_pkg::ProbW-1:0]          s;
  logic signed [lgh_pkg::GradW:0]     g_raw;
  logic signed [lgh_pkg::GradW-1:0]   g;
  logic [lgh_pkg::ProbW-1:0]          om;
  logic [31:0]                        hprod;
  logic [31:0]                        hsum;
  logic [lgh_pkg::HessW-1:0]          h;

  logic                               out_valid_q;
  logic                               skid_full_q;
  logic [lgh_pkg::ProbW-1:0]          prob_q, skid_prob_q;
  logic signed [lgh_pkg::GradW-1:0]   grad_q, skid_grad_q;
  logic [lgh_pkg::HessW-1:0]          hess_q, skid_hess_q;
  logic                               take;
  logic                               new_v;
  logic                               load_out;
  logic                               load_skid;
  logic                               drain_skid;

  // Clamp sigmoid
  assign s = (quo_i > lgh_pkg::OneQ15) ? lgh_pkg::OneQ15 : quo_i;

  // Gradient, saturated below
  assign g_raw = $signed({2'b00, s}) - $signed({2'b00, tag_i.label});
  assign g     = (g_raw < lgh_pkg::GradMin) ? lgh_pkg::GradW'(lgh_pkg::GradMin)
                                            : g_raw[lgh_pkg::GradW-1:0];

  // Hessian, rounded to nearest
  assign om    = lgh_pkg::OneQ15 - s;
  assign hprod = s * om;
  assign hsum  = hprod + lgh_pkg::HessRound;
  assign h     = hsum[28:15];

  // Pipeline moves while the skid entry is free
  assign en_o       = !skid_full_q;
  assign take       = out_valid_q && !out_stall_i;
  assign new_v      = tag_i.valid && en_o;
  assign load_out   = en_o && (!out_valid_q || take);
  assign load_skid  = new_v && out_valid_q && !take;
  assign drain_skid = skid_full_q && take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else begin
      if (drain_skid) begin
        out_valid_q <= 1'b1;
        skid_full_q <= 1'b0;
      end else begin
        if (load_out) begin
          out_valid_q <= new_v;
        end
        if (load_skid) begin
          skid_full_q <= 1'b1;
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (drain_skid) begin
      prob_q <= skid_prob_q;
      grad_q <= skid_grad_q;
      hess_q <= skid_hess_q;
    end else if (load_out && new_v) begin
      prob_q <= s;
      grad_q <= g;
      hess_q <= h;
    end
    if (load_skid) begin
      skid_prob_q <= s;
      skid_grad_q <= g;
      skid_hess_q <= h;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign probability_o = prob_q;
  assign gradient_o    = grad_q;
  assign hessian_o     = hess_q;

endmodule

>>> rtl/core/logistic_gradient_hessian.sv
// ----------------------------------------------------------------------------
// logistic_gradient_hessian
// Logistic-loss gradient and hessian with the sigmoid probability.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries one request: a Q5.10 logit
//   and a label (32768 is 1.0). A request is taken on a clock edge with
//   in_valid_i high and in_stall_o low.
//   Output channel out_valid_o / out_stall_i carries probability, gradient
//   and hessian, all scaled so that 32768 is 1.0; a result is taken on an
//   edge with out_valid_o high and out_stall_i low.
//   From request to result a value passes four stages for the power of two,
//   two for forming the divider operands, sixteen restoring divider stages
//   (one quotient bit each) and the output register.
//   Throughput is one request per cycle while the output is not stalled.
//   A stalled result holds in the output register; one more result lands in
//   a skid entry, after which in_stall_o rises (a registered signal) and the
//   whole pipeline holds until the skid entry drains.
//   Reset clears every valid bit; the block takes requests from the first
//   edge after reset is released.
// ----------------------------------------------------------------------------
module logistic_gradient_hessian (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [lgh_pkg::LogitW-1:0]   logit_i,
  input  logic [lgh_pkg::LabelW-1:0]          label_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lgh_pkg::ProbW-1:0]           probability_o,
  output logic signed [lgh_pkg::GradW-1:0]    gradient_o,
  output logic [lgh_pkg::HessW-1:0]           hessian_o
);

  logic                              en;
  lgh_pkg::tag_t                     tag_in, tag_exp, tag_div;
  logic signed [lgh_pkg::ShW-1:0]    n_exp;
  logic [lgh_pkg::PW-1:0]            p_exp;
  logic [lgh_pkg::QuoW-1:0]          quo;

  // Request tag
  assign tag_in.valid = in_valid_i;
  assign tag_in.label = label_i;
  assign in_stall_o   = !en;

  lgh_exp2 u_exp2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .tag_i   (tag_in),
    .logit_i (logit_i),
    .tag_o   (tag_exp),
    .n_o     (n_exp),
    .p_o     (p_exp)
  );

  lgh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (tag_exp),
    .n_i    (n_exp),
    .p_i    (p_exp),
    .tag_o  (tag_div),
    .quo_o  (quo)
  );

  lgh_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tag_i         (tag_div),
    .quo_i         (quo),
    .en_o          (en),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .probability_o (probability_o),
    .gradient_o    (gradient_o),
    .hessian_o     (hessian_o)
  );

endmodule

>>> rtl/core/lgh_checker.sv
// ----------------------------------------------------------------------------
// lgh_checker
// Port-level checks on the logistic gradient/hessian block.
// ----------------------------------------------------------------------------
module lgh_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [lgh_pkg::ProbW-1:0]           probability_o,
  input logic signed [lgh_pkg::GradW-1:0]    gradient_o,
  input logic [lgh_pkg::HessW-1:0]           hessian_o
);

  // Probability stays in [0, 1]
  a_prob_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> probability_o <= 16'd32768)
    else $error("probability above one");

  // Hessian is zero at either end of the sigmoid
  a_hess_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (probability_o == 16'd0 || probability_o == 16'd32768)
      |-> hessian_o == 14'd0)
    else $error("hessian not zero at saturated probability");

  // Hessian at most one quarter
  a_hess_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hessian_o <= 14'd8192)
    else $error("hessian above one quarter");

  // Gradient within [-1, 1]
  a_grad_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (gradient_o >= -17'sd32768) && (gradient_o <= 17'sd32768))
    else $error("gradient out of range");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(probability_o)
      && $stable(gradient_o) && $stable(hessian_o))
    else $error("stalled result changed");

endmodule

bind logistic_gradient_hessian lgh_checker u_lgh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .probability_o (probability_o),
  .gradient_o    (gradient_o),
  .hessian_o     (hessian_o)
);
